@@ src/bfo_pkg.sv @@
// Shared constants, codes, state and control types, and the ring index and
// capacity clamp helpers for the byte ring FIFO. Depends on nothing.
`default_nettype none

package bfo_pkg;

   localparam int DEPTH  = 256;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_GET   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_REJECTED = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic accept;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } stat_type;

   function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] idx,
                                                   input logic [CNT_W-1:0]  cap);
      logic [CNT_W-1:0] n;
      n = CNT_W'(idx) + CNT_W'(1);
      return (n >= cap) ? '0 : n[ADDR_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] clamp_capacity(input logic [CNT_W-1:0] value);
      logic [CNT_W-1:0] c;
      c = value;
      if (c == '0)
         c = CNT_W'(1);
      if (c > CNT_W'(DEPTH))
         c = CNT_W'(DEPTH);
      return c;
   endfunction

endpackage

`default_nettype wire

@@ src/bfo_ctrl.sv @@
// Controller for the byte ring FIFO: takes an item, then commits it
// once the result register is free. Depends on bfo_pkg.
`default_nettype none

module bfo_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bfo_pkg::stat_type stat,
   output bfo_pkg::cmd_type       cmd
);

   bfo_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= bfo_pkg::ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfo_pkg::ST_IDLE: begin
            if (req_valid)
               state_in = bfo_pkg::ST_EXEC;
         end
         bfo_pkg::ST_EXEC: begin
            // hold until the previous result has been taken
            if (!stat.out_busy)
               state_in = bfo_pkg::ST_IDLE;
         end
         default: state_in = bfo_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         bfo_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         bfo_pkg::ST_EXEC: begin
            cmd.commit = !stat.out_busy;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

@@ src/bfo_datapath.sv @@
// Datapath for the byte ring FIFO: slot memory, ring indices, fill count,
// capacity register and result register. Depends on bfo_pkg.
`default_nettype none

module bfo_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bfo_pkg::cmd_type           cmd,
   output bfo_pkg::stat_type               stat,
   input  wire logic [1:0]                 req_kind,
   input  wire logic [7:0]                 req_data_in,
   input  wire logic                       req_overwrite,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [7:0]                      rsp_data_out,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_dropped_oldest,
   output logic [bfo_pkg::CNT_W-1:0]       rsp_fill_count,
   output logic                            rsp_is_full,
   output logic                            rsp_is_empty,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [bfo_pkg::CNT_W-1:0]  csr_capacity
);

   logic [7:0] slots [bfo_pkg::DEPTH];

   logic [bfo_pkg::ADDR_W-1:0] write_index_ff, write_index_in;
   logic [bfo_pkg::ADDR_W-1:0] read_index_ff, read_index_in;
   logic [bfo_pkg::CNT_W-1:0]  held_count_ff, held_count_in;
   logic [bfo_pkg::CNT_W-1:0]  cap_ff;

   logic [1:0] kind_ff;
   logic [7:0] data_ff;
   logic       ovw_ff;
   logic [7:0] rd_data_ff;

   logic       rsp_valid_ff;
   logic [7:0] data_out_ff, data_out_in;
   logic [1:0] status_ff, status_in;
   logic       dropped_ff, dropped_in;
   logic [bfo_pkg::CNT_W-1:0] fill_ff;
   logic       full_ff;
   logic       empty_ff;
   logic       mem_we;

   assign csr_ready     = 1'b1;
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;

   // capture the item and read the oldest byte in the same cycle
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff    <= req_kind;
         data_ff    <= req_data_in;
         ovw_ff     <= req_overwrite;
         rd_data_ff <= slots[read_index_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         slots[write_index_ff] <= data_ff;
   end

   always_comb begin
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      held_count_in  = held_count_ff;
      data_out_in    = 8'd0;
      status_in      = bfo_pkg::STATUS_OK;
      dropped_in     = 1'b0;
      mem_we         = 1'b0;
      case (kind_ff)
         bfo_pkg::KIND_PUT: begin
            if (held_count_ff < cap_ff) begin
               mem_we         = cmd.commit;
               write_index_in = bfo_pkg::ring_next(write_index_ff, cap_ff);
               held_count_in  = held_count_ff + bfo_pkg::CNT_W'(1);
            end else if (ovw_ff) begin
               // drop the oldest byte
               mem_we         = cmd.commit;
               write_index_in = bfo_pkg::ring_next(write_index_ff, cap_ff);
               read_index_in  = bfo_pkg::ring_next(read_index_ff, cap_ff);
               held_count_in  = cap_ff;
               dropped_in     = 1'b1;
            end else begin
               status_in = bfo_pkg::STATUS_REJECTED;
            end
         end
         bfo_pkg::KIND_GET: begin
            if (held_count_ff == '0) begin
               status_in = bfo_pkg::STATUS_EMPTY;
            end else begin
               data_out_in   = rd_data_ff;
               read_index_in = bfo_pkg::ring_next(read_index_ff, cap_ff);
               held_count_in = held_count_ff - bfo_pkg::CNT_W'(1);
            end
         end
         bfo_pkg::KIND_CLEAR: begin
            write_index_in = '0;
            read_index_in  = '0;
            held_count_in  = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff         <= bfo_pkg::CNT_W'(bfo_pkg::DEPTH);
         write_index_ff <= '0;
         read_index_ff  <= '0;
         held_count_ff  <= '0;
      end else if (csr_valid) begin
         cap_ff         <= bfo_pkg::clamp_capacity(csr_capacity);
         write_index_ff <= '0;
         read_index_ff  <= '0;
         held_count_ff  <= '0;
      end else if (cmd.commit) begin
         write_index_ff <= write_index_in;
         read_index_ff  <= read_index_in;
         held_count_ff  <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.commit)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         data_out_ff <= data_out_in;
         status_ff   <= status_in;
         dropped_ff  <= dropped_in;
         fill_ff     <= held_count_in;
         full_ff     <= (held_count_in == cap_ff);
         empty_ff    <= (held_count_in == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_out       = data_out_ff;
   assign rsp_status         = status_ff;
   assign rsp_dropped_oldest = dropped_ff;
   assign rsp_fill_count     = fill_ff;
   assign rsp_is_full        = full_ff;
   assign rsp_is_empty       = empty_ff;

endmodule

`default_nettype wire

@@ src/byte_ring_fifo_overwrite_unit.sv @@
// Byte ring FIFO with overwrite: one result per put, get or clear item.
// An item is taken in an accept step that reads the slot memory, then
// committed in a step that updates the ring and the result register; the
// next item waits for that commit, which waits while a result is not taken.
// Reset: synchronous, empties the ring and sets capacity to the full depth;
// slot contents are left as they are.
`default_nettype none

module byte_ring_fifo_overwrite_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_kind,
   input  wire logic [7:0]                 req_data_in,
   input  wire logic                       req_overwrite,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [7:0]                      rsp_data_out,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_dropped_oldest,
   output logic [bfo_pkg::CNT_W-1:0]       rsp_fill_count,
   output logic                            rsp_is_full,
   output logic                            rsp_is_empty,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [bfo_pkg::CNT_W-1:0]  csr_capacity
);

   bfo_pkg::cmd_type  cmd;
   bfo_pkg::stat_type stat;

   bfo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bfo_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_kind           (req_kind),
      .req_data_in        (req_data_in),
      .req_overwrite      (req_overwrite),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data_out       (rsp_data_out),
      .rsp_status         (rsp_status),
      .rsp_dropped_oldest (rsp_dropped_oldest),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_is_full        (rsp_is_full),
      .rsp_is_empty       (rsp_is_empty),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity       (csr_capacity)
   );

endmodule

`default_nettype wire
